// ===== hw/rtl/mavd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack address/value map decoder package
// Shared types and constants for the map decoder and its testbench.
// ----------------------------------------------------------------------------
package mavd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_KEYHDR   = 3'd1,
        PH_KEYBYTES = 3'd2,
        PH_VALHDR   = 3'd3,
        PH_VALBYTES = 3'd4,
        PH_DONE     = 3'd5
    } t_phase;

    localparam logic [7:0] MAP_HDR     = 8'h82;
    localparam logic [7:0] FIXSTR_MASK = 8'hE0;
    localparam logic [7:0] FIXSTR_TAG  = 8'hA0;
    localparam logic [7:0] TYPE_U8     = 8'hCC;
    localparam logic [7:0] TYPE_U16    = 8'hCD;
    localparam logic [7:0] TYPE_U32    = 8'hCE;

    localparam logic [4:0] KEY_POS_MAX = 5'd31;
    localparam logic [2:0] SEEN_MIN    = 3'd4;

    localparam logic [7:0] ADDR_TEXT [4] = '{8'h61, 8'h64, 8'h64, 8'h72};
    localparam logic [7:0] VAL_TEXT  [3] = '{8'h76, 8'h61, 8'h6C};

endpackage

// ===== hw/rtl/mavd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack map decoder channels
// Valid/ready channels for payload bytes in and decode results out.
// ----------------------------------------------------------------------------
interface mavd_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mavd_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] address;
    logic [7:0]  value;

    modport source (output valid, output ok, output address, output value, input ready);
    modport sink   (input valid, input ok, input address, input value, output ready);
endinterface

// ===== hw/rtl/msgpack_addr_val_map_decoder.sv =====
`timescale 1ns / 1ps
// The result is registered and appears in the cycle after the request that carries the last byte.
// Throughput: one payload byte per cycle, unless a waiting result stalls the request side.
// A waiting result blocks new bytes only in cycles where the response side is not ready.
// Reset clears the parser to expect a map header and empties the result register.
// ----------------------------------------------------------------------------
// MessagePack address/value map decoder
// Parses a fixmap of two pairs and reports the addr and val entries.
// ----------------------------------------------------------------------------
module msgpack_addr_val_map_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mavd_req_if.sink        i_req,
    mavd_rsp_if.source      o_rsp
);

    mavd_pkg::t_phase r_phase, n_phase;
    logic        r_pair_index, n_pair_index;
    logic [4:0]  r_key_left, n_key_left;
    logic [4:0]  r_key_pos, n_key_pos;
    logic        r_could_addr, n_could_addr;
    logic        r_could_val, n_could_val;
    logic [2:0]  r_val_left, n_val_left;
    logic [15:0] r_val_shift, n_val_shift;
    logic [2:0]  r_bytes_seen, n_bytes_seen;
    logic        r_have_addr, n_have_addr;
    logic        r_have_val, n_have_val;
    logic [15:0] r_held_addr, n_held_addr;
    logic [7:0]  r_held_val, n_held_val;
    logic        r_failed, n_failed;

    logic        r_out_valid;
    logic        r_ok;
    logic [15:0] r_address;
    logic [7:0]  r_value;

    logic        w_acc;
    logic        w_fin;
    logic [15:0] w_fin_val;
    logic        w_ok;
    logic [7:0]  w_b;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_b         = i_req.data_byte;

    always_comb begin
        n_phase      = r_phase;
        n_pair_index = r_pair_index;
        n_key_left   = r_key_left;
        n_key_pos    = r_key_pos;
        n_could_addr = r_could_addr;
        n_could_val  = r_could_val;
        n_val_left   = r_val_left;
        n_val_shift  = r_val_shift;
        n_bytes_seen = r_bytes_seen;
        n_have_addr  = r_have_addr;
        n_have_val   = r_have_val;
        n_held_addr  = r_held_addr;
        n_held_val   = r_held_val;
        n_failed     = r_failed;
        w_fin        = 1'b0;
        w_fin_val    = 16'd0;
        if (r_bytes_seen < mavd_pkg::SEEN_MIN) begin
            n_bytes_seen = r_bytes_seen + 3'd1;
        end
        if (!r_failed) begin
            unique case (r_phase)
                mavd_pkg::PH_HEADER: begin
                    if (w_b != mavd_pkg::MAP_HDR) begin
                        n_failed = 1'b1;
                    end else begin
                        n_phase = mavd_pkg::PH_KEYHDR;
                    end
                end
                mavd_pkg::PH_KEYHDR: begin
                    if ((w_b & mavd_pkg::FIXSTR_MASK) != mavd_pkg::FIXSTR_TAG) begin
                        n_failed = 1'b1;
                    end else begin
                        n_key_left   = w_b[4:0];
                        n_key_pos    = 5'd0;
                        n_could_addr = 1'b1;
                        n_could_val  = 1'b1;
                        if (w_b[4:0] == 5'd0) begin
                            n_could_addr = 1'b0;
                            n_could_val  = 1'b0;
                            n_phase      = mavd_pkg::PH_VALHDR;
                        end else begin
                            n_phase = mavd_pkg::PH_KEYBYTES;
                        end
                    end
                end
                mavd_pkg::PH_KEYBYTES: begin
                    if (r_key_pos < 5'd4) begin
                        if (w_b != mavd_pkg::ADDR_TEXT[r_key_pos[1:0]]) begin
                            n_could_addr = 1'b0;
                        end
                    end else if (r_key_pos == 5'd4) begin
                        if (w_b != 8'd0) begin
                            n_could_addr = 1'b0;
                        end
                    end
                    if (r_key_pos < 5'd3) begin
                        if (w_b != mavd_pkg::VAL_TEXT[r_key_pos[1:0]]) begin
                            n_could_val = 1'b0;
                        end
                    end else if (r_key_pos == 5'd3) begin
                        if (w_b != 8'd0) begin
                            n_could_val = 1'b0;
                        end
                    end
                    if (r_key_pos < mavd_pkg::KEY_POS_MAX) begin
                        n_key_pos = r_key_pos + 5'd1;
                    end
                    n_key_left = r_key_left - 5'd1;
                    if (n_key_left == 5'd0) begin
                        if (n_key_pos < 5'd4) begin
                            n_could_addr = 1'b0;
                        end
                        if (n_key_pos < 5'd3) begin
                            n_could_val = 1'b0;
                        end
                        n_phase = mavd_pkg::PH_VALHDR;
                    end
                end
                mavd_pkg::PH_VALHDR: begin
                    n_val_shift = 16'd0;
                    if (!w_b[7]) begin
                        w_fin     = 1'b1;
                        w_fin_val = {8'd0, w_b};
                    end else if (w_b == mavd_pkg::TYPE_U8) begin
                        n_val_left = 3'd1;
                        n_phase    = mavd_pkg::PH_VALBYTES;
                    end else if (w_b == mavd_pkg::TYPE_U16) begin
                        n_val_left = 3'd2;
                        n_phase    = mavd_pkg::PH_VALBYTES;
                    end else if (w_b == mavd_pkg::TYPE_U32) begin
                        n_val_left = 3'd4;
                        n_phase    = mavd_pkg::PH_VALBYTES;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                mavd_pkg::PH_VALBYTES: begin
                    n_val_shift = {r_val_shift[7:0], w_b};
                    n_val_left  = r_val_left - 3'd1;
                    if (n_val_left == 3'd0) begin
                        w_fin     = 1'b1;
                        w_fin_val = n_val_shift;
                    end
                end
                mavd_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
        if (w_fin) begin
            if (r_could_addr) begin
                n_held_addr = w_fin_val;
                n_have_addr = 1'b1;
            end
            if (r_could_val) begin
                n_held_val = w_fin_val[7:0];
                n_have_val = 1'b1;
            end
            if (!r_pair_index) begin
                n_pair_index = 1'b1;
                n_phase      = mavd_pkg::PH_KEYHDR;
            end else begin
                n_phase = mavd_pkg::PH_DONE;
            end
        end
    end

    always_comb begin
        w_ok = !n_failed && (n_phase == mavd_pkg::PH_DONE) && n_have_addr && n_have_val
            && (n_bytes_seen >= mavd_pkg::SEEN_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_req.last_byte)) begin
            r_phase      <= mavd_pkg::PH_HEADER;
            r_pair_index <= 1'b0;
            r_key_left   <= 5'd0;
            r_key_pos    <= 5'd0;
            r_could_addr <= 1'b0;
            r_could_val  <= 1'b0;
            r_val_left   <= 3'd0;
            r_val_shift  <= 16'd0;
            r_bytes_seen <= 3'd0;
            r_have_addr  <= 1'b0;
            r_have_val   <= 1'b0;
            r_held_addr  <= 16'd0;
            r_held_val   <= 8'd0;
            r_failed     <= 1'b0;
        end else if (w_acc) begin
            r_phase      <= n_phase;
            r_pair_index <= n_pair_index;
            r_key_left   <= n_key_left;
            r_key_pos    <= n_key_pos;
            r_could_addr <= n_could_addr;
            r_could_val  <= n_could_val;
            r_val_left   <= n_val_left;
            r_val_shift  <= n_val_shift;
            r_bytes_seen <= n_bytes_seen;
            r_have_addr  <= n_have_addr;
            r_have_val   <= n_have_val;
            r_held_addr  <= n_held_addr;
            r_held_val   <= n_held_val;
            r_failed     <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && i_req.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_req.last_byte) begin
            r_ok      <= w_ok;
            r_address <= w_ok ? n_held_addr : 16'd0;
            r_value   <= w_ok ? n_held_val : 8'd0;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.ok      = r_ok;
    assign o_rsp.address = r_address;
    assign o_rsp.value   = r_value;

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_req.last_byte |=> r_phase == mavd_pkg::PH_HEADER && !r_failed
            && !r_pair_index)
        else $error("Parser did not restart after the last byte.");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_req.last_byte |=> r_out_valid)
        else $error("Last byte produced no result.");

    a_fail_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> r_address == 16'd0 && r_value == 8'd0)
        else $error("Failed result carries nonzero fields.");

    a_done_second_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == mavd_pkg::PH_DONE |-> r_pair_index)
        else $error("Parser finished before the second pair.");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MessagePack address/value map decoder
// Streams well-formed, damaged and random payloads through the request
// channel with random idling on both sides. A byte-level parser model
// predicts each decode result, and every result taken from the response
// channel is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         RANDOM_ITEMS   = 950;
    localparam int         TAIL_ITEMS     = 150;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_EVERY    = 50;
    localparam logic [7:0] FIXINT_MAX     = 8'h7F;
    localparam logic [7:0] KEY_NUL        = 8'h00;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain_first;
    } t_payload_byte;

    typedef struct packed {
        logic        ok;
        logic [15:0] address;
        logic [7:0]  value;
    } t_decode_result;

    typedef enum int {
        KEY_ADDR,
        KEY_VAL,
        KEY_ADDR_NUL,
        KEY_VAL_NUL,
        KEY_NEAR,
        KEY_NOISE
    } t_key_kind;

    typedef enum int {
        VAL_FIXINT,
        VAL_U8,
        VAL_U16,
        VAL_U32
    } t_val_kind;

    logic i_clk;
    logic i_rst_n;

    mavd_req_if req_ch ();
    mavd_rsp_if rsp_ch ();

    msgpack_addr_val_map_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_payload_byte  payload_bytes_q[$];
    t_decode_result expected_maps_q[$];
    logic [7:0]     frame_q[$];
    int             fail_count = 0;
    int             idle_cycles = 0;
    bit             tail_quiet = 1'b0;

    // Parser model state.
    mavd_pkg::t_phase map_phase;
    logic        second_pair;
    logic [4:0]  key_left;
    logic [4:0]  key_pos;
    logic        maybe_addr;
    logic        maybe_val;
    logic [2:0]  num_left;
    logic [15:0] num_acc;
    logic [2:0]  seen_cnt;
    logic        saw_addr;
    logic        saw_val;
    logic [15:0] addr_reg;
    logic [7:0]  val_reg;
    logic        broken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        map_phase   = mavd_pkg::PH_HEADER;
        second_pair = 1'b0;
        key_left    = '0;
        key_pos     = '0;
        maybe_addr  = 1'b0;
        maybe_val   = 1'b0;
        num_left    = '0;
        num_acc     = '0;
        seen_cnt    = '0;
        saw_addr    = 1'b0;
        saw_val     = 1'b0;
        addr_reg    = '0;
        val_reg     = '0;
        broken      = 1'b0;
    endfunction

    function automatic void close_key();
        if (key_pos < 5'd4) maybe_addr = 1'b0;
        if (key_pos < 5'd3) maybe_val = 1'b0;
        map_phase = mavd_pkg::PH_VALHDR;
    endfunction

    function automatic void close_value(input logic [15:0] v);
        if (maybe_addr) begin
            addr_reg = v;
            saw_addr = 1'b1;
        end
        if (maybe_val) begin
            val_reg = v[7:0];
            saw_val = 1'b1;
        end
        if (!second_pair) begin
            second_pair = 1'b1;
            map_phase   = mavd_pkg::PH_KEYHDR;
        end else begin
            map_phase = mavd_pkg::PH_DONE;
        end
    endfunction

    task automatic track_payload_byte(input logic [7:0] b, input logic last);
        t_decode_result r;
        if (seen_cnt < mavd_pkg::SEEN_MIN) seen_cnt++;
        if (!broken) begin
            case (map_phase)
                mavd_pkg::PH_HEADER: begin
                    if (b != mavd_pkg::MAP_HDR) broken = 1'b1;
                    else map_phase = mavd_pkg::PH_KEYHDR;
                end
                mavd_pkg::PH_KEYHDR: begin
                    if ((b & mavd_pkg::FIXSTR_MASK) != mavd_pkg::FIXSTR_TAG) begin
                        broken = 1'b1;
                    end else begin
                        key_left   = b[4:0];
                        key_pos    = '0;
                        maybe_addr = 1'b1;
                        maybe_val  = 1'b1;
                        if (key_left == '0) close_key();
                        else map_phase = mavd_pkg::PH_KEYBYTES;
                    end
                end
                mavd_pkg::PH_KEYBYTES: begin
                    if (key_pos < 5'd4) begin
                        if (b != mavd_pkg::ADDR_TEXT[key_pos]) maybe_addr = 1'b0;
                    end else if (key_pos == 5'd4) begin
                        if (b != KEY_NUL) maybe_addr = 1'b0;
                    end
                    if (key_pos < 5'd3) begin
                        if (b != mavd_pkg::VAL_TEXT[key_pos]) maybe_val = 1'b0;
                    end else if (key_pos == 5'd3) begin
                        if (b != KEY_NUL) maybe_val = 1'b0;
                    end
                    if (key_pos < mavd_pkg::KEY_POS_MAX) key_pos++;
                    key_left--;
                    if (key_left == '0) close_key();
                end
                mavd_pkg::PH_VALHDR: begin
                    num_acc = '0;
                    if (b <= FIXINT_MAX) begin
                        close_value({8'h00, b});
                    end else if (b == mavd_pkg::TYPE_U8) begin
                        num_left  = 3'd1;
                        map_phase = mavd_pkg::PH_VALBYTES;
                    end else if (b == mavd_pkg::TYPE_U16) begin
                        num_left  = 3'd2;
                        map_phase = mavd_pkg::PH_VALBYTES;
                    end else if (b == mavd_pkg::TYPE_U32) begin
                        num_left  = 3'd4;
                        map_phase = mavd_pkg::PH_VALBYTES;
                    end else begin
                        broken = 1'b1;
                    end
                end
                mavd_pkg::PH_VALBYTES: begin
                    num_acc = {num_acc[7:0], b};
                    num_left--;
                    if (num_left == '0) close_value(num_acc);
                end
                default: ;
            endcase
        end
        if (last) begin
            r.ok      = !broken && map_phase == mavd_pkg::PH_DONE && saw_addr && saw_val &&
                        seen_cnt >= mavd_pkg::SEEN_MIN;
            r.address = r.ok ? addr_reg : 16'h0000;
            r.value   = r.ok ? val_reg : 8'h00;
            expected_maps_q.push_back(r);
            clear_parser();
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_key(input t_key_kind kind);
        logic [7:0] text[$];
        int         cut;
        case (kind)
            KEY_ADDR, KEY_ADDR_NUL: begin
                for (int i = 0; i < 4; i++) text.push_back(mavd_pkg::ADDR_TEXT[i]);
            end
            KEY_VAL, KEY_VAL_NUL: begin
                for (int i = 0; i < 3; i++) text.push_back(mavd_pkg::VAL_TEXT[i]);
            end
            KEY_NEAR: begin
                if ($urandom_range(0, 1)) begin
                    for (int i = 0; i < 4; i++) text.push_back(mavd_pkg::ADDR_TEXT[i]);
                end else begin
                    for (int i = 0; i < 3; i++) text.push_back(mavd_pkg::VAL_TEXT[i]);
                end
                case ($urandom_range(0, 2))
                    0: void'(text.pop_back());
                    1: begin
                        cut = $urandom_range(0, text.size() - 1);
                        text[cut] = text[cut] ^ 8'($urandom_range(1, 255));
                    end
                    default: text.push_back(8'($urandom_range(1, 255)));
                endcase
            end
            default: repeat ($urandom_range(0, 31)) text.push_back(8'($urandom));
        endcase
        if (kind == KEY_ADDR_NUL || kind == KEY_VAL_NUL) begin
            text.push_back(KEY_NUL);
            repeat ($urandom_range(0, 31 - text.size())) text.push_back(8'($urandom));
        end
        frame_q.push_back(mavd_pkg::FIXSTR_TAG | 8'(text.size()));
        foreach (text[i]) frame_q.push_back(text[i]);
    endtask

    task automatic add_value(input t_val_kind kind, input logic [31:0] v);
        case (kind)
            VAL_FIXINT: frame_q.push_back({1'b0, v[6:0]});
            VAL_U8: begin
                frame_q.push_back(mavd_pkg::TYPE_U8);
                frame_q.push_back(v[7:0]);
            end
            VAL_U16: begin
                frame_q.push_back(mavd_pkg::TYPE_U16);
                frame_q.push_back(v[15:8]);
                frame_q.push_back(v[7:0]);
            end
            default: begin
                frame_q.push_back(mavd_pkg::TYPE_U32);
                frame_q.push_back(v[31:24]);
                frame_q.push_back(v[23:16]);
                frame_q.push_back(v[15:8]);
                frame_q.push_back(v[7:0]);
            end
        endcase
    endtask

    task automatic add_pair(input t_key_kind kind);
        add_key(kind);
        add_value(t_val_kind'($urandom_range(0, 3)), rand_word());
    endtask

    task automatic build_random_frame();
        t_key_kind k0;
        t_key_kind k1;
        t_key_kind swap;
        frame_q.push_back(mavd_pkg::MAP_HDR);
        if ($urandom_range(0, 9) < 6) begin
            k0 = ($urandom_range(0, 3) == 0) ? KEY_ADDR_NUL : KEY_ADDR;
            k1 = ($urandom_range(0, 3) == 0) ? KEY_VAL_NUL : KEY_VAL;
            if ($urandom_range(0, 1)) begin
                swap = k0;
                k0   = k1;
                k1   = swap;
            end
        end else begin
            k0 = t_key_kind'($urandom_range(0, 5));
            k1 = t_key_kind'($urandom_range(0, 5));
        end
        add_pair(k0);
        add_pair(k1);
        repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
    endtask

    task automatic emit_frame(input bit drain_first);
        t_payload_byte it;
        foreach (frame_q[i]) begin
            it.data        = frame_q[i];
            it.last        = (i == frame_q.size() - 1);
            it.drain_first = drain_first && (i == 0);
            payload_bytes_q.push_back(it);
        end
        frame_q.delete();
    endtask

    always @(posedge i_clk) begin : driver
        t_payload_byte nxt;
        logic          present;
        int            send_gap;
        if (!i_rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.data_byte <= '0;
            req_ch.last_byte <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                track_payload_byte(req_ch.data_byte, req_ch.last_byte);
            end
            tail_quiet = payload_bytes_q.size() < TAIL_ITEMS;
            present = 1'b0;
            if (req_ch.valid && !req_ch.ready) begin
                present = 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
            end else if (payload_bytes_q.size() > 0) begin
                if (payload_bytes_q[0].drain_first && expected_maps_q.size() != 0) begin
                    // Hold the next payload until every earlier result is back.
                end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 5);
                end else begin
                    nxt = payload_bytes_q.pop_front();
                    present = 1'b1;
                    req_ch.data_byte <= nxt.data;
                    req_ch.last_byte <= nxt.last;
                end
            end
            req_ch.valid <= present;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_decode_result want;
        int             stall_left;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_maps_q.size() == 0) begin
                    $error("unexpected result: ok %0b, address %0h, value %0h",
                           rsp_ch.ok, rsp_ch.address, rsp_ch.value);
                    fail_count++;
                end else begin
                    want = expected_maps_q.pop_front();
                    check_field("ok", 16'(want.ok), 16'(rsp_ch.ok));
                    check_field("address", want.address, rsp_ch.address);
                    check_field("value", 16'(want.value), 16'(rsp_ch.value));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int random_bytes;
        int frames;
        int mode;
        i_rst_n = 1'b0;
        clear_parser();

        // Largest value through the 32-bit type, then a 16-bit value.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_ADDR);
        add_value(VAL_U32, 32'hFFFF_FFFF);
        add_key(KEY_VAL);
        add_value(VAL_U16, 32'h0000_1234);
        emit_frame(1'b0);

        // Reversed key order, fixint extremes and trailing bytes.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_VAL);
        add_value(VAL_FIXINT, 32'h0000_0000);
        add_key(KEY_ADDR);
        add_value(VAL_FIXINT, 32'h0000_007F);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        emit_frame(1'b0);

        // Keys that match because a zero byte ends the text.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_ADDR_NUL);
        add_value(VAL_U8, 32'h0000_00FF);
        add_key(KEY_VAL_NUL);
        add_value(VAL_U32, 32'h0000_0000);
        emit_frame(1'b0);

        // The same key twice leaves the other one missing.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_ADDR);
        add_value(VAL_U16, 32'h0000_0000);
        add_key(KEY_ADDR);
        add_value(VAL_U8, 32'h0000_0005);
        emit_frame(1'b0);

        // Header alone, then a wrong header.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        emit_frame(1'b0);
        frame_q.push_back(8'h83);
        emit_frame(1'b0);

        // Key header outside the fixstr range.
        frame_q = '{mavd_pkg::MAP_HDR, 8'h90, 8'h00};
        emit_frame(1'b0);

        // Value type bytes just outside the accepted ranges.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_ADDR);
        frame_q.push_back(8'hCB);
        add_key(KEY_VAL);
        frame_q.push_back(8'h00);
        emit_frame(1'b0);
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_ADDR);
        frame_q.push_back(8'h80);
        emit_frame(1'b0);
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_VAL);
        frame_q.push_back(8'hCF);
        emit_frame(1'b0);

        // Payload cut inside a value, and one under four bytes.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        add_key(KEY_ADDR);
        frame_q.push_back(mavd_pkg::TYPE_U32);
        frame_q.push_back(8'h01);
        frame_q.push_back(8'h02);
        emit_frame(1'b0);
        frame_q = '{mavd_pkg::MAP_HDR, 8'hA3, 8'h76};
        emit_frame(1'b0);

        // Two empty keys.
        frame_q = '{mavd_pkg::MAP_HDR, mavd_pkg::FIXSTR_TAG, 8'h00, mavd_pkg::FIXSTR_TAG,
                    FIXINT_MAX};
        emit_frame(1'b0);

        // Keys that only resemble the expected ones.
        frame_q = '{mavd_pkg::MAP_HDR, 8'hA5, 8'h61, 8'h64, 8'h64, 8'h72, 8'h58, 8'h01,
                    8'hA2, 8'h76, 8'h61, 8'h02};
        emit_frame(1'b0);

        // Longest key, beginning with the address text and a zero byte.
        frame_q.push_back(mavd_pkg::MAP_HDR);
        frame_q.push_back(mavd_pkg::FIXSTR_TAG | 8'h1F);
        for (int i = 0; i < 4; i++) frame_q.push_back(mavd_pkg::ADDR_TEXT[i]);
        frame_q.push_back(KEY_NUL);
        repeat (26) frame_q.push_back(8'($urandom));
        add_value(VAL_U16, 32'h0000_FFFF);
        add_key(KEY_VAL);
        add_value(VAL_FIXINT, 32'h0000_007F);
        emit_frame(1'b0);

        random_bytes = 0;
        frames = 0;
        while (random_bytes < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            if (mode < 8) begin
                build_random_frame();
            end else if (mode == 8) begin
                build_random_frame();
                if ($urandom_range(0, 1)) begin
                    frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
                end else begin
                    frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
                end
            end else begin
                repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
            end
            random_bytes += frame_q.size();
            emit_frame(frames % DRAIN_EVERY == 0);
            frames++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (payload_bytes_q.size() != 0 || req_ch.valid || expected_maps_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_maps_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
